FILE: hw/rtl/avf_pkg.sv
// Shared types, widths and codes for the aspect viewport fit pipeline.
`default_nettype none
package avf_pkg;

    localparam int DIM_W   = 13;
    localparam int RATIO_W = 24;
    localparam int RD_W    = 17;
    localparam int PROD_W  = 37;
    localparam int NUM_W   = 39;
    localparam int DEN_W   = 26;
    localparam int QUO_W   = 14;
    localparam int POS_W   = 16;
    localparam int ACC_W   = 18;
    localparam int ZPROD_W = 22;
    localparam int ZOOM_W  = 9;
    localparam int ADJ_W   = 13;

    localparam logic [2:0] MODE_CORE     = 3'd0;
    localparam logic [2:0] MODE_STRETCH  = 3'd1;
    localparam logic [2:0] MODE_FOUR3    = 3'd2;
    localparam logic [2:0] MODE_SIXTEEN9 = 3'd3;
    localparam logic [2:0] MODE_CUSTOM   = 3'd4;
    localparam logic [2:0] MODE_ZOOM     = 3'd5;

    localparam logic [2:0] REG_FIT_MODE      = 3'd0;
    localparam logic [2:0] REG_OFFSET_X      = 3'd1;
    localparam logic [2:0] REG_OFFSET_Y      = 3'd2;
    localparam logic [2:0] REG_WIDTH_ADJUST  = 3'd3;
    localparam logic [2:0] REG_HEIGHT_ADJUST = 3'd4;
    localparam logic [2:0] REG_ZOOM_PERCENT  = 3'd5;

    localparam logic [ZOOM_W-1:0] ZOOM_MIN   = 9'd10;
    localparam logic [ZOOM_W-1:0] ZOOM_MAX   = 9'd500;
    localparam logic [ZOOM_W-1:0] ZOOM_RESET = 9'd100;

    // floor(v / 100) = (v * ZOOM_RECIP) >> ZOOM_SHIFT for v below 2^22
    localparam logic [22:0] ZOOM_RECIP = 23'd5368710;
    localparam int          ZOOM_SHIFT = 29;

    typedef struct packed {
        logic [DIM_W-1:0] ww;
        logic [DIM_W-1:0] wh;
        logic             wide;
    } side_t;

    typedef struct packed {
        logic [2:0]              mode;
        logic signed [ADJ_W-1:0] offset_x;
        logic signed [ADJ_W-1:0] offset_y;
        logic signed [ADJ_W-1:0] width_adjust;
        logic signed [ADJ_W-1:0] height_adjust;
        logic [ZOOM_W-1:0]       zoom_percent;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] view_x;
        logic [POS_W-1:0] view_y;
        logic [POS_W-1:0] view_w;
        logic [POS_W-1:0] view_h;
    } view_t;

    function automatic logic signed [ACC_W-1:0] half_tz(input logic signed [ACC_W-1:0] d);
        logic signed [ACC_W-1:0] t;
        t = d + ACC_W'(d[ACC_W-1]);
        return t >>> 1;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aspect_viewport_fit.sv
// Inputs pass the ratio, divider and placement stages to the output register.
// One item per cycle unless stalled; 14 quotient stages set the pipeline depth.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears valid bits and loads the configuration defaults (zoom 100).
// Top level: configuration registers, ratio stages, divider and placement stages.
`default_nettype none
module aspect_viewport_fit
#(
    parameter int MIN_CUSTOM_SIZE = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // window_width, window_height, source_width, source_height, source_ratio
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // view_x, view_y, view_w, view_h
    output logic [63:0]      m_tdata
);

    avf_pkg::cfg_t                 cfg_reg;
    logic                          en;
    logic                          r_valid, d_valid, p_valid;
    logic [avf_pkg::NUM_W-1:0]     num;
    logic [avf_pkg::DEN_W-1:0]     den;
    avf_pkg::side_t                r_side, d_side;
    logic [avf_pkg::QUO_W-1:0]     quo;
    avf_pkg::view_t                view;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: avf_pkg::MODE_CORE, offset_x: '0, offset_y: '0,
                         width_adjust: '0, height_adjust: '0,
                         zoom_percent: avf_pkg::ZOOM_RESET};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                avf_pkg::REG_FIT_MODE:      cfg_reg.mode          <= cfg_data[2:0];
                avf_pkg::REG_OFFSET_X:      cfg_reg.offset_x      <= cfg_data;
                avf_pkg::REG_OFFSET_Y:      cfg_reg.offset_y      <= cfg_data;
                avf_pkg::REG_WIDTH_ADJUST:  cfg_reg.width_adjust  <= cfg_data;
                avf_pkg::REG_HEIGHT_ADJUST: cfg_reg.height_adjust <= cfg_data;
                avf_pkg::REG_ZOOM_PERCENT:  cfg_reg.zoom_percent  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    assign en       = !p_valid || m_tready;
    assign s_tready = en;

    avf_ratio u_ratio
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .ww        (s_tdata[12:0]),
        .wh        (s_tdata[25:13]),
        .sw        (s_tdata[38:26]),
        .sh        (s_tdata[51:39]),
        .sr        (s_tdata[75:52]),
        .mode      (cfg_reg.mode),
        .out_valid (r_valid),
        .num       (num),
        .den       (den),
        .side      (r_side)
    );

    avf_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .num       (num),
        .den       (den),
        .in_side   (r_side),
        .out_valid (d_valid),
        .quo       (quo),
        .out_side  (d_side)
    );

    avf_post #(.MIN_SIZE(MIN_CUSTOM_SIZE)) u_post
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .quo       (quo),
        .side      (d_side),
        .cfg       (cfg_reg),
        .out_valid (p_valid),
        .view      (view)
    );

    assign m_tvalid = p_valid;
    assign m_tdata  = {view.view_h, view.view_w, view.view_y, view.view_x};

endmodule
`default_nettype wire

FILE: hw/rtl/avf_ratio.sv
// Ratio selection, cross products and division operand forming (three stages).
`default_nettype none
module avf_ratio
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             en,
    input  wire logic                             in_valid,
    input  wire logic [avf_pkg::DIM_W-1:0]        ww,
    input  wire logic [avf_pkg::DIM_W-1:0]        wh,
    input  wire logic [avf_pkg::DIM_W-1:0]        sw,
    input  wire logic [avf_pkg::DIM_W-1:0]        sh,
    input  wire logic [avf_pkg::RATIO_W-1:0]      sr,
    input  wire logic [2:0]                       mode,
    output logic                                  out_valid,
    output logic [avf_pkg::NUM_W-1:0]             num,
    output logic [avf_pkg::DEN_W-1:0]             den,
    output avf_pkg::side_t                        side
);

    logic                            v1_reg, v2_reg, v3_reg;
    logic [avf_pkg::RATIO_W-1:0]     rn1_reg, rn2_reg, rn_next;
    logic [avf_pkg::RD_W-1:0]        rd1_reg, rd2_reg, rd_next;
    logic [avf_pkg::DIM_W-1:0]       ww1_reg, wh1_reg, ww2_reg, wh2_reg;
    logic [avf_pkg::PROD_W-1:0]      p1_reg, p2_reg;
    logic [avf_pkg::NUM_W-1:0]       num_reg, num_next;
    logic [avf_pkg::DEN_W-1:0]       den_reg, den_next;
    avf_pkg::side_t                  side_reg;
    logic                            wide;

    always_comb
    begin
        priority if (mode == avf_pkg::MODE_FOUR3)
        begin
            rn_next = avf_pkg::RATIO_W'(4);
            rd_next = avf_pkg::RD_W'(3);
        end
        else if (mode == avf_pkg::MODE_SIXTEEN9)
        begin
            rn_next = avf_pkg::RATIO_W'(16);
            rd_next = avf_pkg::RD_W'(9);
        end
        else if (sr != '0)
        begin
            rn_next = sr;
            rd_next = avf_pkg::RD_W'(65536);
        end
        else if (sw != '0 && sh != '0)
        begin
            rn_next = avf_pkg::RATIO_W'(sw);
            rd_next = avf_pkg::RD_W'(sh);
        end
        else
        begin
            rn_next = avf_pkg::RATIO_W'(4);
            rd_next = avf_pkg::RD_W'(3);
        end
    end

    assign wide = p1_reg > p2_reg;

    always_comb
    begin
        if (wide)
        begin
            num_next = {p2_reg, 1'b0} + avf_pkg::NUM_W'(rd2_reg);
            den_next = {avf_pkg::DEN_W'(rd2_reg) << 1};
        end
        else
        begin
            num_next = {p1_reg, 1'b0} + avf_pkg::NUM_W'(rn2_reg);
            den_next = {avf_pkg::DEN_W'(rn2_reg) << 1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rn1_reg  <= rn_next;
            rd1_reg  <= rd_next;
            ww1_reg  <= ww;
            wh1_reg  <= wh;
            p1_reg   <= avf_pkg::PROD_W'(ww1_reg) * avf_pkg::PROD_W'(rd1_reg);
            p2_reg   <= avf_pkg::PROD_W'(wh1_reg) * avf_pkg::PROD_W'(rn1_reg);
            rn2_reg  <= rn1_reg;
            rd2_reg  <= rd1_reg;
            ww2_reg  <= ww1_reg;
            wh2_reg  <= wh1_reg;
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= '{ww: ww2_reg, wh: wh2_reg, wide: wide};
        end
    end

    assign out_valid = v3_reg;
    assign num       = num_reg;
    assign den       = den_reg;
    assign side      = side_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/avf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module avf_div
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [avf_pkg::NUM_W-1:0]    num,
    input  wire logic [avf_pkg::DEN_W-1:0]    den,
    input  wire avf_pkg::side_t               in_side,
    output logic                              out_valid,
    output logic [avf_pkg::QUO_W-1:0]         quo,
    output avf_pkg::side_t                    out_side
);

    localparam int N = avf_pkg::QUO_W;

    logic                          vld   [0:N];
    logic [avf_pkg::NUM_W-1:0]     rem   [0:N];
    logic [avf_pkg::DEN_W-1:0]     dv    [0:N];
    logic [avf_pkg::QUO_W-1:0]     qv    [0:N];
    avf_pkg::side_t                sd    [0:N];

    assign vld[0] = in_valid;
    assign rem[0] = num;
    assign dv[0]  = den;
    assign qv[0]  = '0;
    assign sd[0]  = in_side;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic                       vld_reg;
        logic [avf_pkg::NUM_W-1:0]  rem_reg, rem_next;
        logic [avf_pkg::DEN_W-1:0]  den_reg;
        logic [avf_pkg::QUO_W-1:0]  quo_reg, quo_next;
        avf_pkg::side_t             side_reg;
        logic [avf_pkg::NUM_W-1:0]  trial;

        assign trial = avf_pkg::NUM_W'(dv[k]) << (N - 1 - k);

        always_comb
        begin
            rem_next = rem[k];
            quo_next = qv[k];
            if (rem[k] >= trial)
            begin
                rem_next           = rem[k] - trial;
                quo_next[N - 1 - k] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                den_reg  <= dv[k];
                quo_reg  <= quo_next;
                side_reg <= sd[k];
            end
        end

        assign vld[k+1] = vld_reg;
        assign rem[k+1] = rem_reg;
        assign dv[k+1]  = den_reg;
        assign qv[k+1]  = quo_reg;
        assign sd[k+1]  = side_reg;
    end

    assign out_valid = vld[N];
    assign quo       = qv[N];
    assign out_side  = sd[N];

endmodule
`default_nettype wire

FILE: hw/rtl/avf_post.sv
// Placement, zoom scaling, custom adjust and mode select (three stages).
`default_nettype none
module avf_post
#(
    parameter int MIN_SIZE = 64
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [avf_pkg::QUO_W-1:0]   quo,
    input  wire avf_pkg::side_t              side,
    input  wire avf_pkg::cfg_t               cfg,
    output logic                             out_valid,
    output avf_pkg::view_t                   view
);

    localparam int A = avf_pkg::ACC_W;
    localparam logic signed [A-1:0] MIN_S = A'(MIN_SIZE);

    logic                      v1_reg, v2_reg, v3_reg;
    logic signed [A-1:0]       fx1_reg, fy1_reg, fx_next, fy_next;
    logic [avf_pkg::QUO_W-1:0] fw1_reg, fh1_reg, fw_next, fh_next;
    logic [avf_pkg::ZPROD_W-1:0] zw1_reg, zh1_reg;
    logic [avf_pkg::DIM_W-1:0] ww1_reg, wh1_reg, ww2_reg, wh2_reg;
    logic [avf_pkg::ZOOM_W-1:0] zc;

    logic signed [A-1:0]       fx2_reg, fy2_reg, fw2_reg, fh2_reg;
    logic signed [A-1:0]       cx2_reg, cy2_reg, cw2_reg, ch2_reg, cw_next, ch_next;
    logic [avf_pkg::POS_W-1:0] zq_w2_reg, zq_h2_reg;
    logic [44:0]               zmw, zmh;

    avf_pkg::view_t            view_reg, view_next;
    logic signed [A-1:0]       zx, zy;

    always_comb
    begin
        if (side.wide)
        begin
            fw_next = quo;
            fh_next = avf_pkg::QUO_W'(side.wh);
            fx_next = avf_pkg::half_tz(A'(side.ww) - A'(quo));
            fy_next = '0;
        end
        else
        begin
            fw_next = avf_pkg::QUO_W'(side.ww);
            fh_next = quo;
            fx_next = '0;
            fy_next = avf_pkg::half_tz(A'(side.wh) - A'(quo));
        end
        priority if (cfg.zoom_percent < avf_pkg::ZOOM_MIN)
            zc = avf_pkg::ZOOM_MIN;
        else if (cfg.zoom_percent > avf_pkg::ZOOM_MAX)
            zc = avf_pkg::ZOOM_MAX;
        else
            zc = cfg.zoom_percent;
    end

    assign zmw = 45'(zw1_reg) * 45'(avf_pkg::ZOOM_RECIP);
    assign zmh = 45'(zh1_reg) * 45'(avf_pkg::ZOOM_RECIP);

    always_comb
    begin
        cw_next = A'(fw1_reg) + A'(cfg.width_adjust);
        ch_next = A'(fh1_reg) + A'(cfg.height_adjust);
        if (cw_next < MIN_S)
            cw_next = MIN_S;
        if (ch_next < MIN_S)
            ch_next = MIN_S;
    end

    assign zx = avf_pkg::half_tz(A'(ww2_reg) - A'(zq_w2_reg)) + A'(cfg.offset_x);
    assign zy = avf_pkg::half_tz(A'(wh2_reg) - A'(zq_h2_reg)) + A'(cfg.offset_y);

    always_comb
    begin
        unique case (cfg.mode)
            avf_pkg::MODE_STRETCH:
                view_next = '{view_x: '0, view_y: '0,
                              view_w: avf_pkg::POS_W'(ww2_reg),
                              view_h: avf_pkg::POS_W'(wh2_reg)};
            avf_pkg::MODE_ZOOM:
                view_next = '{view_x: zx[avf_pkg::POS_W-1:0],
                              view_y: zy[avf_pkg::POS_W-1:0],
                              view_w: zq_w2_reg, view_h: zq_h2_reg};
            avf_pkg::MODE_CUSTOM:
                view_next = '{view_x: cx2_reg[avf_pkg::POS_W-1:0],
                              view_y: cy2_reg[avf_pkg::POS_W-1:0],
                              view_w: cw2_reg[avf_pkg::POS_W-1:0],
                              view_h: ch2_reg[avf_pkg::POS_W-1:0]};
            default:
                view_next = '{view_x: fx2_reg[avf_pkg::POS_W-1:0],
                              view_y: fy2_reg[avf_pkg::POS_W-1:0],
                              view_w: fw2_reg[avf_pkg::POS_W-1:0],
                              view_h: fh2_reg[avf_pkg::POS_W-1:0]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx1_reg   <= fx_next;
            fy1_reg   <= fy_next;
            fw1_reg   <= fw_next;
            fh1_reg   <= fh_next;
            zw1_reg   <= avf_pkg::ZPROD_W'(fw_next) * avf_pkg::ZPROD_W'(zc);
            zh1_reg   <= avf_pkg::ZPROD_W'(fh_next) * avf_pkg::ZPROD_W'(zc);
            ww1_reg   <= side.ww;
            wh1_reg   <= side.wh;

            fx2_reg   <= fx1_reg;
            fy2_reg   <= fy1_reg;
            fw2_reg   <= A'(fw1_reg);
            fh2_reg   <= A'(fh1_reg);
            cx2_reg   <= fx1_reg + A'(cfg.offset_x);
            cy2_reg   <= fy1_reg + A'(cfg.offset_y);
            cw2_reg   <= cw_next;
            ch2_reg   <= ch_next;
            zq_w2_reg <= zmw[avf_pkg::ZOOM_SHIFT +: avf_pkg::POS_W];
            zq_h2_reg <= zmh[avf_pkg::ZOOM_SHIFT +: avf_pkg::POS_W];
            ww2_reg   <= ww1_reg;
            wh2_reg   <= wh1_reg;

            view_reg  <= view_next;
        end
    end

    assign out_valid = v3_reg;
    assign view      = view_reg;

endmodule
`default_nettype wire

FILE: tb/sv/viewport_checker.sv
// Viewport checker: predicts each viewport from the request stream and compares results.
`default_nettype none
module viewport_checker
    import avf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    output int               fail_count,
    output int               pending
);

    localparam longint MIN_SIZE = 64;

    logic [2:0]        mode;
    logic [ADJ_W-1:0]  off_x;
    logic [ADJ_W-1:0]  off_y;
    logic [ADJ_W-1:0]  adj_w;
    logic [ADJ_W-1:0]  adj_h;
    logic [ZOOM_W-1:0] zoom;
    logic [63:0]       viewport_q[$];

    assign pending = viewport_q.size();

    function automatic logic [63:0] fit_viewport(input logic [79:0] req);
        longint ww, wh, sw, sh, sr, rn, rd, x, y, w, h, z;
        ww = req[12:0];
        wh = req[25:13];
        sw = req[38:26];
        sh = req[51:39];
        sr = req[75:52];
        if (mode == MODE_STRETCH)
        begin
            x = 0;
            y = 0;
            w = ww;
            h = wh;
        end
        else
        begin
            if (mode == MODE_FOUR3)
            begin
                rn = 4;
                rd = 3;
            end
            else if (mode == MODE_SIXTEEN9)
            begin
                rn = 16;
                rd = 9;
            end
            else if (sr != 0)
            begin
                rn = sr;
                rd = 65536;
            end
            else if (sw != 0 && sh != 0)
            begin
                rn = sw;
                rd = sh;
            end
            else
            begin
                rn = 4;
                rd = 3;
            end
            if (ww * rd > rn * wh)
            begin
                h = wh;
                w = (2 * wh * rn + rd) / (2 * rd);
                x = (ww - w) / 2;
                y = 0;
            end
            else
            begin
                w = ww;
                h = (2 * ww * rd + rn) / (2 * rn);
                x = 0;
                y = (wh - h) / 2;
            end
            if (mode == MODE_ZOOM)
            begin
                z = zoom;
                if (z < 10)
                    z = 10;
                if (z > 500)
                    z = 500;
                w = (w * z) / 100;
                h = (h * z) / 100;
                x = (ww - w) / 2 + longint'($signed(off_x));
                y = (wh - h) / 2 + longint'($signed(off_y));
            end
            else if (mode == MODE_CUSTOM)
            begin
                x += longint'($signed(off_x));
                y += longint'($signed(off_y));
                w += longint'($signed(adj_w));
                h += longint'($signed(adj_h));
                if (w < MIN_SIZE)
                    w = MIN_SIZE;
                if (h < MIN_SIZE)
                    h = MIN_SIZE;
            end
        end
        return {h[15:0], w[15:0], y[15:0], x[15:0]};
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
        begin
            mode  <= MODE_CORE;
            off_x <= '0;
            off_y <= '0;
            adj_w <= '0;
            adj_h <= '0;
            zoom  <= ZOOM_RESET;
            fail_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                viewport_q.push_back(fit_viewport(s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (viewport_q.size() == 0)
                begin
                    $display("unexpected result %0h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = viewport_q.pop_front();
                    if (m_tdata[15:0] !== want[15:0])
                        report("view_x", m_tdata[15:0], want[15:0]);
                    if (m_tdata[31:16] !== want[31:16])
                        report("view_y", m_tdata[31:16], want[31:16]);
                    if (m_tdata[47:32] !== want[47:32])
                        report("view_w", m_tdata[47:32], want[47:32]);
                    if (m_tdata[63:48] !== want[63:48])
                        report("view_h", m_tdata[63:48], want[63:48]);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FIT_MODE:      mode  <= cfg_data[2:0];
                    REG_OFFSET_X:      off_x <= cfg_data;
                    REG_OFFSET_Y:      off_y <= cfg_data;
                    REG_WIDTH_ADJUST:  adj_w <= cfg_data;
                    REG_HEIGHT_ADJUST: adj_h <= cfg_data;
                    REG_ZOOM_PERCENT:  zoom  <= cfg_data[8:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench top: drives requests and configuration, stalls both sides, gives the verdict.
`default_nettype none
module testbench;
    import avf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    int          fail_count;
    int          pending;
    int          cycles;
    bit          hold_long;
    bit          hold_req;

    aspect_viewport_fit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    viewport_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [12:0] rand_dim();
        case ($urandom_range(0, 5))
            0: return 13'($urandom_range(0, 3));
            1: return 13'd8191;
            2: return 13'($urandom_range(8000, 8191));
            3: return 13'($urandom_range(1, 64));
            default: return 13'($urandom_range(0, 8191));
        endcase
    endfunction

    function automatic logic [79:0] rand_request();
        logic [23:0] sr;
        case ($urandom_range(0, 4))
            0: sr = 24'd0;
            1: sr = 24'hFFFFFF;
            2: sr = 24'($urandom_range(1, 3));
            default: sr = 24'($urandom_range(0, 24'hFFFFFF));
        endcase
        return {4'd0, sr, rand_dim(), rand_dim(), rand_dim(), rand_dim()};
    endfunction

    task automatic send(input logic [79:0] req);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (25) @(posedge clk);
    endtask

    task automatic write_all(input logic [2:0] m, input logic [12:0] ox, input logic [12:0] oy,
                             input logic [12:0] aw, input logic [12:0] ah,
                             input logic [12:0] z);
        write_reg(REG_FIT_MODE, 13'(m));
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_WIDTH_ADJUST, aw);
        write_reg(REG_HEIGHT_ADJUST, ah);
        write_reg(REG_ZOOM_PERCENT, z);
    endtask

    initial
    begin
        hold_long = 1'b0;
        @(posedge hold_req);
        hold_long <= 1'b1;
        repeat (300) @(posedge clk);
        hold_long <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_long)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 99) < 5);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cycles    = 0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset configuration, extremes and fallbacks
        send({4'd0, 24'd0, 13'd0, 13'd0, 13'd1080, 13'd1920});
        send({4'd0, 24'd0, 13'd480, 13'd640, 13'd1080, 13'd1920});
        send({4'd0, 24'h020000, 13'd0, 13'd0, 13'd8191, 13'd8191});
        send({4'd0, 24'hFFFFFF, 13'd8191, 13'd8191, 13'd1, 13'd8191});
        send({4'd0, 24'd1, 13'd0, 13'd0, 13'd8191, 13'd1});
        send({4'd0, 24'd0, 13'd0, 13'd5, 13'd0, 13'd0});
        send({4'd0, 24'd0, 13'd0, 13'd0, 13'd768, 13'd1024});
        drain();
        for (int m = 0; m < 8; m++)
        begin
            write_all(3'(m), 13'h1000, 13'h0FFF, 13'h1000, 13'h0FFF, 13'(m == 5 ? 9 : 500));
            send({4'd0, 24'd0, 13'd0, 13'd0, 13'd1080, 13'd1920});
            send({4'd0, 24'hFFFFFF, 13'd0, 13'd0, 13'd8191, 13'd8191});
            send({4'd0, 24'd0, 13'd0, 13'd0, 13'd0, 13'd0});
            drain();
        end
        write_all(MODE_ZOOM, 13'h1FFF, 13'h0001, 13'd0, 13'd0, 13'd511);
        send({4'd0, 24'd0, 13'd9, 13'd16, 13'd4000, 13'd8191});
        drain();

        // random phases, one with a long receiver hold-off
        for (int p = 0; p < 12; p++)
        begin
            write_all(3'($urandom_range(0, 7)), 13'($urandom), 13'($urandom),
                      13'($urandom), 13'($urandom),
                      13'($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                    : $urandom_range(10, 500)));
            if (p == 4)
                hold_req <= 1'b1;
            for (int i = 0; i < 95; i++)
                send(rand_request());
            drain();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
